FILE: rtl/fpd_pkg.sv
`default_nettype none

package fpd_pkg;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_START  = 7'b0000001,
    ST_WAIT   = 7'b0000010,
    ST_LAUNCH = 7'b0000100,
    ST_HIGH   = 7'b0001000,
    ST_FALL   = 7'b0010000,
    ST_NEAR   = 7'b0100000,
    ST_LANDED = 7'b1000000
  } state_t;

  // Phase codes as reported on the result stream
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_LAUNCH = 3'd2;
  localparam logic [2:0] PH_HIGH   = 3'd3;
  localparam logic [2:0] PH_FALL   = 3'd4;
  localparam logic [2:0] PH_NEAR   = 3'd5;
  localparam logic [2:0] PH_LANDED = 3'd6;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_POWER  = 3'd1,
    EV_LAUNCH = 3'd2,
    EV_APEX   = 3'd3,
    EV_NEAR   = 3'd4,
    EV_GROUND = 3'd5
  } event_t;

  // Register map, word index
  localparam logic [1:0] REG_LAUNCH_LIMIT = 2'd0;
  localparam logic [1:0] REG_HIGH_ALT     = 2'd1;
  localparam logic [1:0] REG_LOW_ALT      = 2'd2;
  localparam logic [1:0] REG_SCALE        = 2'd3;

  localparam logic signed [15:0] RstLaunchLimit = 16'sd2;
  localparam logic [14:0]        RstHighAlt     = 15'd500;
  localparam logic [14:0]        RstLowAlt      = 15'd200;
  localparam logic [15:0]        RstScale       = 16'd5455;

  localparam int QueueDepth = 4;

  typedef struct packed {
    logic signed [15:0] launch_limit;
    logic [14:0]        high_alt;
    logic [14:0]        low_alt;
    logic [15:0]        scale;
  } cfg_t;

  // One classified tick; alt_raw is floor(diff * scale / 2^16), not yet clamped
  typedef struct packed {
    logic               smp;
    logic               launch;
    logic signed [18:0] alt_raw;
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic [15:0]        az;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [2:0] phase_code(input state_t st);
    logic [2:0] c;
    case (st)
      ST_START:  c = PH_START;
      ST_WAIT:   c = PH_WAIT;
      ST_LAUNCH: c = PH_LAUNCH;
      ST_HIGH:   c = PH_HIGH;
      ST_FALL:   c = PH_FALL;
      ST_NEAR:   c = PH_NEAR;
      default:   c = PH_LANDED;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fpd_front.sv
`default_nettype none

module fpd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fpd_pkg::cfg_t cfg,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [71:0]   in_tdata,
  input  wire logic          in_tuser,
  input  wire logic          q_full,
  output logic               push,
  output fpd_pkg::qent_t     push_data
);

  logic               stage_v_r, stage_v_nxt;
  fpd_pkg::qent_t     stage_r;
  logic [16:0]        ref_r;
  logic               cap_r, cap_nxt;
  logic               accept;
  logic [16:0]        p;
  logic [16:0]        ref_eff;
  logic signed [17:0] diff;
  logic signed [34:0] prod;
  logic               first_smp;

  assign in_tready = !stage_v_r || !q_full;
  assign push      = stage_v_r && !q_full;
  assign push_data = stage_r;
  assign accept    = in_tvalid && in_tready;

  assign p         = in_tdata[16:0];
  assign first_smp = in_tuser && !cap_r;
  // the first sample is its own reference, so its altitude is zero
  assign ref_eff   = first_smp ? p : ref_r;
  assign diff      = signed'({1'b0, ref_eff}) - signed'({1'b0, p});
  assign prod      = diff * signed'({1'b0, cfg.scale});

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (accept) begin
      stage_v_nxt = 1'b1;
    end else if (push) begin
      stage_v_nxt = 1'b0;
    end
    cap_nxt = cap_r || (accept && in_tuser);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      cap_r     <= 1'b0;
      ref_r     <= '0;
    end else begin
      stage_v_r <= stage_v_nxt;
      cap_r     <= cap_nxt;
      if (accept && first_smp) begin
        ref_r <= p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r.smp     <= in_tuser;
      stage_r.launch  <= signed'(in_tdata[64:49]) <= cfg.launch_limit;
      stage_r.alt_raw <= prod[34:16];
      stage_r.ax      <= in_tdata[32:17];
      stage_r.ay      <= in_tdata[48:33];
      stage_r.az      <= in_tdata[64:49];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fpd_queue.sv
`default_nettype none

module fpd_queue #(
  parameter int DEPTH = fpd_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire fpd_pkg::qent_t  push_data,
  input  wire logic            pop,
  output fpd_pkg::qent_t       pop_data,
  output fpd_pkg::qstat_t      stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  fpd_pkg::qent_t  mem_r [DEPTH];
  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == FullCnt);
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == LastPtr) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LastPtr) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fpd_back.sv
`default_nettype none

module fpd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fpd_pkg::cfg_t   cfg,
  input  wire fpd_pkg::qstat_t qstat,
  input  wire fpd_pkg::qent_t  q_data,
  output logic                 pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [23:0]          out_tdata
);

  fpd_pkg::state_t    st_r, st_nxt;
  logic signed [15:0] prev_alt_r;
  logic [15:0]        prev_ax_r, prev_ay_r, prev_az_r;
  logic               landed_rep_r, landed_rep_nxt;
  logic               out_v_r, out_v_nxt;
  logic [2:0]         out_phase_r;
  fpd_pkg::event_t    out_ev_r, ev;
  logic signed [15:0] out_alt_r;
  logic signed [15:0] sat_alt, alt;
  logic               store_accel;
  logic               same_accel;

  assign pop        = !qstat.empty && (!out_v_r || out_tready);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_alt_r, out_ev_r, out_phase_r};

  always_comb begin
    if (q_data.alt_raw > 19'sd32767) begin
      sat_alt = 16'sh7fff;
    end else if (q_data.alt_raw < -19'sd32768) begin
      sat_alt = 16'sh8000;
    end else begin
      sat_alt = q_data.alt_raw[15:0];
    end
  end

  assign alt        = q_data.smp ? sat_alt : prev_alt_r;
  assign same_accel = (prev_ax_r == q_data.ax) && (prev_ay_r == q_data.ay) &&
                      (prev_az_r == q_data.az);

  always_comb begin
    st_nxt         = st_r;
    ev             = fpd_pkg::EV_NONE;
    landed_rep_nxt = landed_rep_r;
    store_accel    = 1'b0;
    case (st_r)
      fpd_pkg::ST_START: begin
        if (q_data.smp) begin
          ev     = fpd_pkg::EV_POWER;
          st_nxt = fpd_pkg::ST_WAIT;
        end
      end
      fpd_pkg::ST_WAIT: begin
        if (q_data.smp && q_data.launch) begin
          ev     = fpd_pkg::EV_LAUNCH;
          st_nxt = fpd_pkg::ST_LAUNCH;
        end
      end
      fpd_pkg::ST_LAUNCH: begin
        if (q_data.smp && (alt > signed'({1'b0, cfg.high_alt}))) begin
          st_nxt = fpd_pkg::ST_HIGH;
        end
      end
      fpd_pkg::ST_HIGH: begin
        if (q_data.smp && (alt < prev_alt_r)) begin
          ev     = fpd_pkg::EV_APEX;
          st_nxt = fpd_pkg::ST_FALL;
        end
      end
      fpd_pkg::ST_FALL: begin
        if (q_data.smp && (alt < signed'({1'b0, cfg.low_alt}))) begin
          ev          = fpd_pkg::EV_NEAR;
          st_nxt      = fpd_pkg::ST_NEAR;
          store_accel = 1'b1;
        end
      end
      fpd_pkg::ST_NEAR: begin
        if (q_data.smp) begin
          store_accel = 1'b1;
          if (same_accel) begin
            st_nxt = fpd_pkg::ST_LANDED;
          end
        end
      end
      default: begin
        // on-ground is raised on the first tick spent landed, valid or not
        if (!landed_rep_r) begin
          ev             = fpd_pkg::EV_GROUND;
          landed_rep_nxt = 1'b1;
        end
        st_nxt = fpd_pkg::ST_LANDED;
      end
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (pop) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= fpd_pkg::ST_START;
      landed_rep_r <= 1'b0;
      out_v_r      <= 1'b0;
      prev_alt_r   <= '0;
      prev_ax_r    <= '0;
      prev_ay_r    <= '0;
      prev_az_r    <= '0;
    end else begin
      out_v_r <= out_v_nxt;
      if (pop) begin
        st_r         <= st_nxt;
        landed_rep_r <= landed_rep_nxt;
        if (q_data.smp) begin
          prev_alt_r <= alt;
        end
        if (store_accel) begin
          prev_ax_r <= q_data.ax;
          prev_ay_r <= q_data.ay;
          prev_az_r <= q_data.az;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_phase_r <= fpd_pkg::phase_code(st_nxt);
      out_ev_r    <= ev;
      out_alt_r   <= alt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/flight_phase_detector_unit.sv
// Flight phase tracker.
// in_*  : one request per tick. in_tuser = sample_valid; in_tdata carries
//         pressure and the three acceleration axes. A tick without a sample
//         still yields a result.
// out_* : exactly one result per tick, in order: phase, event and altitude.
// cfg_* : APB-style registers: launch limit (0x0), high altitude (0x4),
//         low altitude (0x8), metres-per-pascal Q0.16 scale (0xC). Write
//         only while no tick is in flight.
// A result passes the input stage, the queue and the sequencer output
// register in turn. Throughput: one tick per cycle while the result stream
// is not stalled, set by the sequencer stepping on each queue entry it pops.
// Reset: synchronous, rst_n low. Registers go to their defaults, the phase
// to start, the reference pressure and saved samples to zero.
// Output stall: the result register holds; the queue between the input
// stage and the sequencer keeps filling, and in_tready drops only once the
// queue and the input stage are both full.
`default_nettype none

module flight_phase_detector_unit #(
  parameter int QUEUE_DEPTH = fpd_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [16:0] pressure_pa, [32:17] accel_x, [48:33] accel_y, [64:49] accel_z
  input  wire logic [71:0] in_tdata,
  // [0] sample_valid
  input  wire logic        in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] phase, [5:3] event_code, [21:6] altitude_m
  output logic [23:0]      out_tdata,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  fpd_pkg::cfg_t   cfg_r;
  fpd_pkg::qent_t  push_data, pop_data;
  fpd_pkg::qstat_t qstat;
  logic            push, pop;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.launch_limit <= fpd_pkg::RstLaunchLimit;
      cfg_r.high_alt     <= fpd_pkg::RstHighAlt;
      cfg_r.low_alt      <= fpd_pkg::RstLowAlt;
      cfg_r.scale        <= fpd_pkg::RstScale;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        fpd_pkg::REG_LAUNCH_LIMIT: cfg_r.launch_limit <= cfg_pwdata[15:0];
        fpd_pkg::REG_HIGH_ALT:     cfg_r.high_alt     <= cfg_pwdata[14:0];
        fpd_pkg::REG_LOW_ALT:      cfg_r.low_alt      <= cfg_pwdata[14:0];
        fpd_pkg::REG_SCALE:        cfg_r.scale        <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      fpd_pkg::REG_LAUNCH_LIMIT:
        cfg_prdata = {{16{cfg_r.launch_limit[15]}}, cfg_r.launch_limit};
      fpd_pkg::REG_HIGH_ALT: cfg_prdata = {17'd0, cfg_r.high_alt};
      fpd_pkg::REG_LOW_ALT:  cfg_prdata = {17'd0, cfg_r.low_alt};
      fpd_pkg::REG_SCALE:    cfg_prdata = {16'd0, cfg_r.scale};
      default:               cfg_prdata = '0;
    endcase
  end

  fpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (qstat.full),
    .push      (push),
    .push_data (push_data)
  );

  fpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  fpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .qstat      (qstat),
    .q_data     (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // input stage is empty straight after reset
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // a stalled result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("push into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fpd_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic               smp;
    logic [16:0]        pres;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } tick_t;

  typedef struct packed {
    logic [2:0]         phase;
    event_t             ev;
    logic signed [15:0] alt;
  } report_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  flight_phase_detector_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Tracker copy: registers and flight state
  logic signed [15:0] acc_limit  = 16'sd2;
  logic [14:0]        climb_alt  = 15'd500;
  logic [14:0]        ground_alt = 15'd200;
  logic [15:0]        scale_q16  = 16'd5455;
  logic [2:0]         flight_ph  = PH_START;
  logic [16:0]        ref_pa     = '0;
  logic signed [15:0] last_alt   = '0;
  logic [15:0]        held_ax = '0, held_ay = '0, held_az = '0;
  bit                 ground_told = 1'b0;

  tick_t   ticks_pending[$];
  report_t due_reports[$];
  tick_t   cur_tick;
  bit      tick_taken = 1'b0;
  bit      calm = 1'b0;
  int      hold_asked = 0;
  int      fault_count = 0;
  int      ticks_made = 0;
  int      results_seen = 0;
  int      reg_writes = 0;
  int      cycles = 0;
  logic [15:0] sl_ax = '0, sl_ay = '0, sl_az = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t %s", $time, msg);
  endfunction

  // floor(diff * scale / 2^16), clamped to 16 bits
  function automatic logic signed [15:0] altitude_at(input logic [16:0] pres);
    longint diff, prod;
    diff = longint'(ref_pa) - longint'(pres);
    prod = (diff * longint'(scale_q16)) >>> 16;
    if (prod > 32767) return 16'h7fff;
    if (prod < -32768) return 16'h8000;
    return prod[15:0];
  endfunction

  function automatic report_t predict_tick(input tick_t t);
    report_t r;
    logic signed [15:0] a;
    r.ev = EV_NONE;
    if (t.smp && flight_ph == PH_START) ref_pa = t.pres;
    a = t.smp ? altitude_at(t.pres) : last_alt;
    case (flight_ph)
      PH_START: if (t.smp) begin
        r.ev = EV_POWER;
        flight_ph = PH_WAIT;
      end
      PH_WAIT: if (t.smp && t.az <= acc_limit) begin
        r.ev = EV_LAUNCH;
        flight_ph = PH_LAUNCH;
      end
      PH_LAUNCH: if (t.smp && int'(a) > int'(climb_alt)) flight_ph = PH_HIGH;
      PH_HIGH: if (t.smp && a < last_alt) begin
        r.ev = EV_APEX;
        flight_ph = PH_FALL;
      end
      PH_FALL: if (t.smp && int'(a) < int'(ground_alt)) begin
        r.ev = EV_NEAR;
        flight_ph = PH_NEAR;
        held_ax = t.ax;
        held_ay = t.ay;
        held_az = t.az;
      end
      PH_NEAR: if (t.smp) begin
        if (held_ax == t.ax && held_ay == t.ay && held_az == t.az) flight_ph = PH_LANDED;
        held_ax = t.ax;
        held_ay = t.ay;
        held_az = t.az;
      end
      default: begin
        if (!ground_told) begin
          r.ev = EV_GROUND;
          ground_told = 1'b1;
        end
        flight_ph = PH_LANDED;
      end
    endcase
    if (t.smp) last_alt = a;
    r.phase = flight_ph;
    r.alt = a;
    return r;
  endfunction

  // Sender: offers the next pending request, holds it until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || tick_taken) begin
      if (ticks_pending.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        cur_tick = ticks_pending.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur_tick.smp;
        in_tdata <= {7'd0, cur_tick.az, cur_tick.ay, cur_tick.ax, cur_tick.pres};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tick_taken = rst_n && in_tvalid && in_tready;
    if (tick_taken) due_reports.push_back(predict_tick(cur_tick));
  end

  // Receiver: random back-pressure plus an occasional long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin : result_check
    report_t want, seen;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_reports.size());
      $display("flight_phase_detector_unit regression: fail");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      seen.phase = out_tdata[2:0];
      seen.ev    = event_t'(out_tdata[5:3]);
      seen.alt   = out_tdata[21:6];
      results_seen++;
      if (due_reports.size() == 0) begin
        log_fault($sformatf("unexpected result: phase %0d event %0d alt %0d",
                            seen.phase, seen.ev, seen.alt));
      end else begin
        want = due_reports.pop_front();
        if (seen.phase !== want.phase || seen.ev !== want.ev || seen.alt !== want.alt)
          log_fault($sformatf(
            "result %0d: want phase %0d event %0d alt %0d, got phase %0d event %0d alt %0d",
            results_seen, want.phase, want.ev, want.alt, seen.phase, seen.ev, seen.alt));
      end
    end
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom());
  endfunction

  task automatic add_tick(input bit smp, input logic [16:0] pres,
                          input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az);
    tick_t t;
    t.smp = smp;
    t.pres = pres;
    t.ax = ax;
    t.ay = ay;
    t.az = az;
    ticks_pending.push_back(t);
    ticks_made++;
    if (smp) begin
      sl_ax = ax;
      sl_ay = ay;
      sl_az = az;
    end
  endtask

  task automatic add_noise();
    add_tick(1'b0, 17'($urandom_range(131071)), rnd16(), rnd16(), rnd16());
  endtask

  task automatic settle();
    while (ticks_pending.size() != 0 || in_tvalid || due_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write then read back; junk above the register width must be dropped
  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] wd, rd;
    bit ok;
    wd = $urandom();
    case (idx)
      REG_HIGH_ALT, REG_LOW_ALT: wd[14:0] = val[14:0];
      default: wd[15:0] = val;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wd;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_LAUNCH_LIMIT: acc_limit = wd[15:0];
      REG_HIGH_ALT:     climb_alt = wd[14:0];
      REG_LOW_ALT:      ground_alt = wd[14:0];
      default:          scale_q16 = wd[15:0];
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_LAUNCH_LIMIT: ok = (rd[15:0] == acc_limit);
      REG_HIGH_ALT:     ok = (rd[14:0] == climb_alt);
      REG_LOW_ALT:      ok = (rd[14:0] == ground_alt);
      default:          ok = (rd[15:0] == scale_q16);
    endcase
    if (!ok) log_fault($sformatf("register %0d read back %h after writing %h", idx, rd, wd));
  endtask

  initial begin
    int base_i, lim_i, d, n, k, b;
    logic [15:0] ax, ay, az;

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    base_i = $urandom_range(80000, 50000);

    // Power-on with reset settings, field extremes, launch limit boundary
    add_tick(1'b0, '1, '1, '1, '1);
    add_tick(1'b0, '0, '0, '0, '0);
    add_tick(1'b1, 17'(base_i), 16'h7fff, 16'h8000, 16'h7fff);
    add_tick(1'b0, '1, 16'h8000, 16'h8000, 16'h8000);
    add_tick(1'b1, '0, 16'h8000, 16'h7fff, 16'd3);
    add_tick(1'b1, '1, 16'h7fff, 16'h0000, 16'h7fff);
    add_tick(1'b1, 17'(base_i + 1), rnd16(), rnd16(), 16'd100);
    add_tick(1'b1, 17'(base_i - 1), rnd16(), rnd16(), 16'd100);
    settle();

    // Register extremes: both clamps while waiting for launch
    set_reg(REG_SCALE, 16'hffff);
    set_reg(REG_LAUNCH_LIMIT, 16'h8000);
    set_reg(REG_HIGH_ALT, 16'h7fff);
    set_reg(REG_LOW_ALT, 16'h0000);
    add_tick(1'b1, '0, rnd16(), rnd16(), 16'h8001);
    add_tick(1'b1, '1, rnd16(), rnd16(), 16'h7fff);
    add_tick(1'b0, 17'(base_i), rnd16(), rnd16(), 16'h8000);
    add_tick(1'b1, 17'(base_i), rnd16(), rnd16(), 16'h0000);
    settle();

    // Waiting for launch: samples above the limit, non-samples below it
    lim_i = -32768 + int'($urandom_range(300));
    set_reg(REG_LAUNCH_LIMIT, 16'(lim_i));
    repeat (300) begin
      if ($urandom_range(99) < 20)
        add_tick(1'b0, 17'($urandom_range(131071)), rnd16(), rnd16(),
                 16'(-32768 + int'($urandom_range(lim_i + 32768))));
      else
        add_tick(1'b1, 17'($urandom_range(131071)), rnd16(), rnd16(),
                 16'(lim_i + 1 + int'($urandom_range(32766 - lim_i))));
    end
    add_tick(1'b1, 17'(base_i), rnd16(), rnd16(), 16'(lim_i));
    settle();

    // Launched, unable to climb: clamped altitude is not above the top
    set_reg(REG_SCALE, 16'hffff);
    add_tick(1'b1, '0, rnd16(), rnd16(), rnd16());
    repeat (150) begin
      if ($urandom_range(99) < 25) add_noise();
      else add_tick(1'b1, 17'($urandom_range(131071)), rnd16(), rnd16(), rnd16());
    end
    settle();
    set_reg(REG_SCALE, rnd16());
    repeat (150) begin
      if ($urandom_range(99) < 25) add_noise();
      else add_tick(1'b1, 17'($urandom_range(131071)), rnd16(), rnd16(), rnd16());
    end
    settle();

    // Climb through the high mark and keep rising, no idling on either side
    set_reg(REG_SCALE, 16'($urandom_range(8000, 4000)));
    set_reg(REG_HIGH_ALT, 16'($urandom_range(1200, 300)));
    calm = 1'b1;
    d = 0;
    repeat (250) begin
      if ($urandom_range(99) < 20) begin
        add_noise();
      end else begin
        d += int'($urandom_range(240));
        if (d > 47000) d = 47000;
        add_tick(1'b1, 17'(base_i - d), rnd16(), rnd16(), rnd16());
      end
    end
    d = 48000;
    add_tick(1'b1, 17'(base_i - d), rnd16(), rnd16(), rnd16());
    settle();
    calm = 1'b0;

    // Apex, then descent below the low mark with the odd upward blip
    set_reg(REG_LOW_ALT, 16'($urandom_range(400, 100)));
    d = d - 100 - int'($urandom_range(300));
    add_tick(1'b1, 17'(base_i - d), rnd16(), rnd16(), rnd16());
    n = 0;
    while (d > 0 && n < 600) begin
      n++;
      if ($urandom_range(99) < 20) begin
        add_noise();
      end else begin
        if ($urandom_range(99) < 10) d += int'($urandom_range(100));
        else d -= int'($urandom_range(400));
        if (d < 0) d = 0;
        add_tick(1'b1, 17'(base_i - d), rnd16(), rnd16(), rnd16());
      end
    end
    repeat (10) add_tick(1'b1, 17'(base_i - int'($urandom_range(100))), rnd16(), rnd16(), rnd16());
    settle();

    // Near ground: near misses on one axis, then a long output hold-off
    calm = 1'b1;
    repeat (300) begin
      k = $urandom_range(99);
      if (k < 20) begin
        add_noise();
      end else if (k < 40) begin
        ax = sl_ax;
        ay = sl_ay;
        az = sl_az;
        b = $urandom_range(15);
        case ($urandom_range(2))
          0: ax[b] = ~ax[b];
          1: ay[b] = ~ay[b];
          default: az[b] = ~az[b];
        endcase
        add_tick(1'b1, 17'($urandom_range(131071)), ax, ay, az);
      end else begin
        add_tick(1'b1, 17'($urandom_range(131071)), rnd16(), rnd16(), rnd16());
      end
    end
    hold_asked++;
    settle();
    calm = 1'b0;

    // Touchdown: a non-sample in between must not disturb the stored axes
    ax = rnd16();
    ay = rnd16();
    az = rnd16();
    add_tick(1'b1, 17'(base_i), ax, ay, az);
    add_tick(1'b0, 17'(base_i), ~ax, ~ay, ~az);
    add_tick(1'b1, 17'(base_i), ax, ay, az);
    settle();

    // Landed: on-ground raised once, altitude still tracked
    set_reg(REG_SCALE, 16'h0000);
    set_reg(REG_HIGH_ALT, 16'h0000);
    set_reg(REG_LOW_ALT, 16'h7fff);
    set_reg(REG_LAUNCH_LIMIT, 16'h7fff);
    repeat (150) begin
      if ($urandom_range(99) < 30) add_noise();
      else add_tick(1'b1, 17'($urandom_range(131071)), rnd16(), rnd16(), rnd16());
    end
    settle();
    set_reg(REG_SCALE, rnd16());
    set_reg(REG_LAUNCH_LIMIT, rnd16());
    repeat (250) begin
      if ($urandom_range(99) < 30) add_noise();
      else add_tick(1'b1, 17'($urandom_range(131071)), rnd16(), rnd16(), rnd16());
    end
    settle();

    repeat (8) @(posedge clk);
    if (due_reports.size() != 0)
      log_fault($sformatf("%0d results never arrived", due_reports.size()));
    $display("%0d ticks driven from power-on to touchdown, %0d results checked",
             ticks_made, results_seen);
    $display("%0d register writes read back, final phase %0d, %0d mismatches",
             reg_writes, flight_ph, fault_count);
    if (fault_count == 0) begin
      $display("flight_phase_detector_unit regression: pass");
    end else begin
      $display("flight_phase_detector_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fpd_pkg.sv
rtl/fpd_front.sv
rtl/fpd_queue.sv
rtl/fpd_back.sv
rtl/flight_phase_detector_unit.sv
verif/testbench.sv
